// File: rtl/ccu_pkg.sv
// ---------------------------------------------------------------------------
// Circle contact unit package
// Mode codes, the per-item context record and saturation limits used by the
// contact pipeline; the testbench checker uses the mode codes as well.
// ---------------------------------------------------------------------------
`default_nettype none

package ccu_pkg;

  localparam logic [1:0] MODE_SEG    = 2'd0;
  localparam logic [1:0] MODE_THICK  = 2'd1;
  localparam logic [1:0] MODE_CIRCLE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [29:0]        r1;
    logic [29:0]        r2;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

endpackage

`default_nettype wire

// File: rtl/circle_contact_unit.sv
// ---------------------------------------------------------------------------
// Circle contact unit
// Fixed-point 2D contact test of a circle against a segment, a thick segment
// or a second circle, giving hit, normal, penetration and contact point.
// ---------------------------------------------------------------------------
// The unit is a single pipeline that takes one query every cycle and returns
// one result per query, in order. The depth is set by the bit-serial units
// laid out as stages: the divider for the closest-point parameter
// (FRAC_BITS stages), the square root of the squared distance (31 stages)
// and the two normal dividers (FRAC_BITS + 1 stages). The whole pipeline
// holds while a finished result is stalled at the output.
`default_nettype none

module circle_contact_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] circle_x,
  input  wire logic signed [31:0] circle_y,
  input  wire logic [29:0]        circle_radius,
  input  wire logic signed [31:0] seg_start_x,
  input  wire logic signed [31:0] seg_start_y,
  input  wire logic signed [31:0] seg_end_x,
  input  wire logic signed [31:0] seg_end_y,
  input  wire logic [29:0]        second_radius,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic signed [17:0]      normal_x,
  output logic signed [17:0]      normal_y,
  output logic [30:0]             penetration,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic                    degenerate
);

  localparam int F      = FRAC_BITS;
  localparam int TW     = F + 1;
  localparam int NW     = F + 2;
  localparam int PW     = 34 + F;
  localparam int OW     = NW + 31;
  localparam int CW     = ccu_pkg::CTX_W;
  localparam int TSIDE  = CW + 64 + 66 + 2;
  localparam int QSIDE  = CW + 66 + 31 + 2;
  localparam int NSIDE  = CW + 1 + 31 + 31 + 2;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: segment and centre offsets.
  logic               s1_v;
  ccu_pkg::ctx_t      s1_ctx;
  logic signed [31:0] s1_sx, s1_sy;
  logic signed [32:0] s1_ddx, s1_ddy, s1_wx, s1_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx.mode <= mode;
      s1_ctx.cx   <= circle_x;
      s1_ctx.cy   <= circle_y;
      s1_ctx.r1   <= circle_radius;
      s1_ctx.r2   <= second_radius;
      s1_sx       <= seg_start_x;
      s1_sy       <= seg_start_y;
      s1_ddx      <= 33'(seg_end_x) - 33'(seg_start_x);
      s1_ddy      <= 33'(seg_end_y) - 33'(seg_start_y);
      s1_wx       <= 33'(circle_x) - 33'(seg_start_x);
      s1_wy       <= 33'(circle_y) - 33'(seg_start_y);
    end
  end

  // Stage 2: dot product terms.
  logic               s2_v;
  ccu_pkg::ctx_t      s2_ctx;
  logic signed [31:0] s2_sx, s2_sy;
  logic signed [32:0] s2_ddx, s2_ddy;
  logic signed [65:0] s2_pwx, s2_pwy, s2_pdx, s2_pdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctx <= s1_ctx;
      s2_sx  <= s1_sx;
      s2_sy  <= s1_sy;
      s2_ddx <= s1_ddx;
      s2_ddy <= s1_ddy;
      s2_pwx <= s1_wx * s1_ddx;
      s2_pwy <= s1_wy * s1_ddy;
      s2_pdx <= s1_ddx * s1_ddx;
      s2_pdy <= s1_ddy * s1_ddy;
    end
  end

  // Stage 3: numerator, denominator and the clamped ends of the parameter.
  logic signed [66:0] s2_num;
  logic [66:0]        s2_den;
  logic               s2_tz, s2_to;

  assign s2_num = 67'(s2_pwx) + 67'(s2_pwy);
  assign s2_den = 67'($unsigned(s2_pdx)) + 67'($unsigned(s2_pdy));
  assign s2_tz  = (s2_den == '0) || (s2_num <= 67'sd0);
  assign s2_to  = !s2_tz && ($unsigned(s2_num) >= s2_den);

  logic               s3_v;
  ccu_pkg::ctx_t      s3_ctx;
  logic signed [31:0] s3_sx, s3_sy;
  logic signed [32:0] s3_ddx, s3_ddy;
  logic [66:0]        s3_num, s3_den;
  logic               s3_tz, s3_to;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctx <= s2_ctx;
      s3_sx  <= s2_sx;
      s3_sy  <= s2_sy;
      s3_ddx <= s2_ddx;
      s3_ddy <= s2_ddy;
      s3_num <= (s2_tz || s2_to) ? '0 : $unsigned(s2_num);
      s3_den <= s2_den;
      s3_tz  <= s2_tz;
      s3_to  <= s2_to;
    end
  end

  // Parameter divider.
  logic               d_v;
  logic [F-1:0]       d_q;
  logic [TSIDE-1:0]   d_side;
  ccu_pkg::ctx_t      d_ctx;
  logic signed [31:0] d_sx, d_sy;
  logic signed [32:0] d_ddx, d_ddy;
  logic               d_tz, d_to;

  ccu_div #(
    .DEN_W(67), .Q_BITS(F), .FIRST_SHIFT(1'b1), .SIDE_W(TSIDE)
  ) u_tdiv (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s3_v),
    .num(s3_num), .den(s3_den),
    .side_in({s3_ctx, s3_sx, s3_sy, s3_ddx, s3_ddy, s3_tz, s3_to}),
    .out_valid(d_v), .quot(d_q), .side_out(d_side)
  );

  assign {d_ctx, d_sx, d_sy, d_ddx, d_ddy, d_tz, d_to} = d_side;

  // Stage 4: offset along the segment.
  logic [TW-1:0] d_t;
  assign d_t = d_tz ? '0 : (d_to ? {1'b1, {F{1'b0}}} : {1'b0, d_q});

  logic                 s4_v;
  ccu_pkg::ctx_t        s4_ctx;
  logic signed [31:0]   s4_sx, s4_sy;
  logic signed [PW-1:0] s4_ox, s4_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctx <= d_ctx;
      s4_sx  <= d_sx;
      s4_sy  <= d_sy;
      s4_ox  <= d_ddx * $signed({1'b0, d_t});
      s4_oy  <= d_ddy * $signed({1'b0, d_t});
    end
  end

  // Stage 5: closest point, difference vector and radius limit.
  localparam logic [PW-1:0] HALF_P = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  logic [PW-1:0]      s4_mx, s4_my, s4_rx, s4_ry;
  logic signed [33:0] s4_offx, s4_offy, s4_px, s4_py, s4_dx, s4_dy;
  logic [30:0]        s4_lim;

  assign s4_mx   = s4_ox[PW-1] ? $unsigned(-s4_ox) : $unsigned(s4_ox);
  assign s4_my   = s4_oy[PW-1] ? $unsigned(-s4_oy) : $unsigned(s4_oy);
  assign s4_rx   = (s4_mx + HALF_P) >> F;
  assign s4_ry   = (s4_my + HALF_P) >> F;
  assign s4_offx = s4_ox[PW-1] ? -$signed(34'(s4_rx)) : $signed(34'(s4_rx));
  assign s4_offy = s4_oy[PW-1] ? -$signed(34'(s4_ry)) : $signed(34'(s4_ry));
  assign s4_px   = (s4_ctx.mode == ccu_pkg::MODE_CIRCLE) ? 34'(s4_sx) : 34'(s4_sx) + s4_offx;
  assign s4_py   = (s4_ctx.mode == ccu_pkg::MODE_CIRCLE) ? 34'(s4_sy) : 34'(s4_sy) + s4_offy;
  assign s4_dx   = (s4_ctx.mode == ccu_pkg::MODE_SEG) ? 34'(s4_ctx.cx) - s4_px
                                                      : s4_px - 34'(s4_ctx.cx);
  assign s4_dy   = (s4_ctx.mode == ccu_pkg::MODE_SEG) ? 34'(s4_ctx.cy) - s4_py
                                                      : s4_py - 34'(s4_ctx.cy);
  assign s4_lim  = (s4_ctx.mode == ccu_pkg::MODE_SEG) ? 31'(s4_ctx.r1)
                                                      : 31'(s4_ctx.r1) + 31'(s4_ctx.r2);

  logic               s5_v;
  ccu_pkg::ctx_t      s5_ctx;
  logic signed [32:0] s5_dx, s5_dy;
  logic [30:0]        s5_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ctx <= s4_ctx;
      s5_dx  <= s4_dx[32:0];
      s5_dy  <= s4_dy[32:0];
      s5_lim <= s4_lim;
    end
  end

  // Stage 6: squares.
  logic [32:0] s5_ax, s5_ay;
  assign s5_ax = s5_dx[32] ? $unsigned(-s5_dx) : $unsigned(s5_dx);
  assign s5_ay = s5_dy[32] ? $unsigned(-s5_dy) : $unsigned(s5_dy);

  logic               s6_v;
  ccu_pkg::ctx_t      s6_ctx;
  logic signed [32:0] s6_dx, s6_dy;
  logic [30:0]        s6_lim;
  logic [65:0]        s6_sqx, s6_sqy;
  logic [61:0]        s6_lim2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ctx  <= s5_ctx;
      s6_dx   <= s5_dx;
      s6_dy   <= s5_dy;
      s6_lim  <= s5_lim;
      s6_sqx  <= s5_ax * s5_ax;
      s6_sqy  <= s5_ay * s5_ay;
      s6_lim2 <= s5_lim * s5_lim;
    end
  end

  // Stage 7: squared distance against the squared limit.
  logic [66:0] s6_sq;
  assign s6_sq = 67'(s6_sqx) + 67'(s6_sqy);

  logic               s7_v;
  ccu_pkg::ctx_t      s7_ctx;
  logic signed [32:0] s7_dx, s7_dy;
  logic [30:0]        s7_lim;
  logic [61:0]        s7_sq;
  logic               s7_hit, s7_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ctx <= s6_ctx;
      s7_dx  <= s6_dx;
      s7_dy  <= s6_dy;
      s7_lim <= s6_lim;
      s7_sq  <= s6_sq[61:0];
      s7_hit <= s6_sq <= 67'(s6_lim2);
      s7_deg <= s6_sq == '0;
    end
  end

  // Distance.
  logic               q_v;
  logic [30:0]        q_len;
  logic [QSIDE-1:0]   q_side;
  ccu_pkg::ctx_t      q_ctx;
  logic signed [32:0] q_dx, q_dy;
  logic [30:0]        q_lim;
  logic               q_hit, q_deg;

  ccu_sqrt #(
    .ROOT_W(31), .SIDE_W(QSIDE)
  ) u_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s7_v), .radicand(s7_sq),
    .side_in({s7_ctx, s7_dx, s7_dy, s7_lim, s7_hit, s7_deg}),
    .out_valid(q_v), .root(q_len), .side_out(q_side)
  );

  assign {q_ctx, q_dx, q_dy, q_lim, q_hit, q_deg} = q_side;

  // Stage 8: magnitudes for the normal dividers.
  logic [32:0] q_ax, q_ay;
  assign q_ax = q_dx[32] ? $unsigned(-q_dx) : $unsigned(q_dx);
  assign q_ay = q_dy[32] ? $unsigned(-q_dy) : $unsigned(q_dy);

  logic          s8_v;
  ccu_pkg::ctx_t s8_ctx;
  logic [30:0]   s8_ax, s8_ay, s8_len, s8_lim;
  logic          s8_nx, s8_ny, s8_hit, s8_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_ctx <= q_ctx;
      s8_ax  <= q_ax[30:0];
      s8_ay  <= q_ay[30:0];
      s8_len <= q_len;
      s8_lim <= q_lim;
      s8_nx  <= q_dx[32];
      s8_ny  <= q_dy[32];
      s8_hit <= q_hit;
      s8_deg <= q_deg;
    end
  end

  // Normal dividers.
  logic             n_v;
  logic [TW-1:0]    n_qx, n_qy;
  logic [NSIDE-1:0] n_side;
  logic             n_sy;
  ccu_pkg::ctx_t    n_ctx;
  logic             n_sx, n_hit, n_deg;
  logic [30:0]      n_lim, n_len;

  ccu_div #(
    .DEN_W(31), .Q_BITS(TW), .FIRST_SHIFT(1'b0), .SIDE_W(NSIDE)
  ) u_ndiv_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s8_v),
    .num(s8_ax), .den(s8_len),
    .side_in({s8_ctx, s8_nx, s8_lim, s8_len, s8_hit, s8_deg}),
    .out_valid(n_v), .quot(n_qx), .side_out(n_side)
  );

  ccu_div #(
    .DEN_W(31), .Q_BITS(TW), .FIRST_SHIFT(1'b0), .SIDE_W(1)
  ) u_ndiv_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s8_v),
    .num(s8_ay), .den(s8_len), .side_in(s8_ny),
    .out_valid(), .quot(n_qy), .side_out(n_sy)
  );

  assign {n_ctx, n_sx, n_lim, n_len, n_hit, n_deg} = n_side;

  // Stage 9: signed normal.
  logic signed [NW-1:0] n_nx, n_ny;
  assign n_nx = n_deg ? '0 : (n_sx ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx}));
  assign n_ny = n_deg ? '0 : (n_sy ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy}));

  logic                 s9_v;
  ccu_pkg::ctx_t        s9_ctx;
  logic signed [NW-1:0] s9_nx, s9_ny;
  logic [30:0]          s9_pen;
  logic                 s9_hit, s9_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_ctx <= n_ctx;
      s9_nx  <= n_nx;
      s9_ny  <= n_ny;
      s9_pen <= n_lim - n_len;
      s9_hit <= n_hit && (n_ctx.mode != ccu_pkg::MODE_NONE);
      s9_deg <= n_deg;
    end
  end

  // Stage 10: normal scaled by the first radius.
  logic                 s10_v;
  ccu_pkg::ctx_t        s10_ctx;
  logic signed [NW-1:0] s10_nx, s10_ny;
  logic signed [OW-1:0] s10_ox, s10_oy;
  logic [30:0]          s10_pen;
  logic                 s10_hit, s10_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (adv) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_ctx <= s9_ctx;
      s10_nx  <= s9_nx;
      s10_ny  <= s9_ny;
      s10_ox  <= s9_nx * $signed({1'b0, s9_ctx.r1});
      s10_oy  <= s9_ny * $signed({1'b0, s9_ctx.r1});
      s10_pen <= s9_pen;
      s10_hit <= s9_hit;
      s10_deg <= s9_deg;
    end
  end

  // Output stage: contact point with rounding and saturation.
  localparam logic [OW-1:0] HALF_O = {{(OW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  logic [OW-1:0]      s10_mx, s10_my, s10_rx, s10_ry;
  logic signed [33:0] s10_offx, s10_offy, s10_ptx, s10_pty;
  logic signed [31:0] s10_satx, s10_saty;

  assign s10_mx   = s10_ox[OW-1] ? $unsigned(-s10_ox) : $unsigned(s10_ox);
  assign s10_my   = s10_oy[OW-1] ? $unsigned(-s10_oy) : $unsigned(s10_oy);
  assign s10_rx   = (s10_mx + HALF_O) >> F;
  assign s10_ry   = (s10_my + HALF_O) >> F;
  assign s10_offx = s10_ox[OW-1] ? -$signed(34'(s10_rx)) : $signed(34'(s10_rx));
  assign s10_offy = s10_oy[OW-1] ? -$signed(34'(s10_ry)) : $signed(34'(s10_ry));
  assign s10_ptx  = (s10_ctx.mode == ccu_pkg::MODE_SEG) ? 34'(s10_ctx.cx) - s10_offx
                                                        : 34'(s10_ctx.cx) + s10_offx;
  assign s10_pty  = (s10_ctx.mode == ccu_pkg::MODE_SEG) ? 34'(s10_ctx.cy) - s10_offy
                                                        : 34'(s10_ctx.cy) + s10_offy;
  assign s10_satx = (s10_ptx > ccu_pkg::SAT_MAX) ? 32'sh7fffffff :
                    (s10_ptx < ccu_pkg::SAT_MIN) ? 32'sh80000000 : s10_ptx[31:0];
  assign s10_saty = (s10_pty > ccu_pkg::SAT_MAX) ? 32'sh7fffffff :
                    (s10_pty < ccu_pkg::SAT_MIN) ? 32'sh80000000 : s10_pty[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit         <= s10_hit;
      normal_x    <= s10_hit ? 18'(s10_nx) : '0;
      normal_y    <= s10_hit ? 18'(s10_ny) : '0;
      penetration <= s10_hit ? s10_pen : '0;
      point_x     <= s10_hit ? s10_satx : '0;
      point_y     <= s10_hit ? s10_saty : '0;
      degenerate  <= s10_hit && s10_deg;
    end
  end

  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (normal_x == '0 && normal_y == '0 && penetration == '0 &&
                             point_x == '0 && point_y == '0 && !degenerate))
    else $error("missed query carries a non-zero field");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (hit && normal_x == '0 && normal_y == '0))
    else $error("degenerate result has a normal or no hit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> (in_stall ##1 (out_valid && $stable(penetration) &&
                                  $stable(point_x) && $stable(point_y))))
    else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

// File: rtl/ccu_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage. The partial remainder must start below
// the divisor, or at most equal to it when the first stage does not shift.
// ---------------------------------------------------------------------------
`default_nettype none

module ccu_div #(
  parameter int DEN_W       = 31,
  parameter int Q_BITS      = 17,
  parameter bit FIRST_SHIFT = 1'b1,
  parameter int SIDE_W      = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DEN_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [Q_BITS-1:0]      quot,
  output logic [SIDE_W-1:0]      side_out
);

  logic [Q_BITS-1:0]              v_q;
  logic [Q_BITS-1:0][DEN_W-1:0]   rem_q;
  logic [Q_BITS-1:0][DEN_W-1:0]   den_q;
  logic [Q_BITS-1:0][Q_BITS-1:0]  quo_q;
  logic [Q_BITS-1:0][SIDE_W-1:0]  side_q;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic              v_p;
    logic [DEN_W-1:0]  rem_p;
    logic [DEN_W-1:0]  den_p;
    logic [Q_BITS-1:0] quo_p;
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W:0]    sh;
    logic              take;
    logic [DEN_W:0]    dif;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = num;
      assign den_p  = den;
      assign quo_p  = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    if (k > 0 || FIRST_SHIFT) begin : g_shift
      assign sh = {rem_p, 1'b0};
    end else begin : g_noshift
      assign sh = {1'b0, rem_p};
    end

    assign take = sh >= {1'b0, den_p};
    assign dif  = sh - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
        den_q[k]  <= den_p;
        quo_q[k]  <= {quo_p[Q_BITS-2:0], take};
        side_q[k] <= side_p;
      end
    end
  end

  assign out_valid = v_q[Q_BITS-1];
  assign quot      = quo_q[Q_BITS-1];
  assign side_out  = side_q[Q_BITS-1];

endmodule

`default_nettype wire

// File: rtl/ccu_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring method, one root bit per register stage, giving
// the floor of the square root of a 2*ROOT_W bit value.
// ---------------------------------------------------------------------------
`default_nettype none

module ccu_sqrt #(
  parameter int ROOT_W = 31,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*ROOT_W-1:0] radicand,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic                     out_valid,
  output logic [ROOT_W-1:0]        root,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int IN_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0]              v_q;
  logic [ROOT_W-1:0][IN_W-1:0]    val_q;
  logic [ROOT_W-1:0][REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0][ROOT_W-1:0]  root_q;
  logic [ROOT_W-1:0][SIDE_W-1:0]  side_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_p;
    logic [IN_W-1:0]   val_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [SIDE_W-1:0] side_p;
    logic [REM_W+1:0]  sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  dif;
    logic              take;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign val_p  = radicand;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign val_p  = val_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign sh    = {rem_p, val_p[IN_W-1:IN_W-2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign take  = sh >= trial;
    assign dif   = sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_q[k]  <= {val_p[IN_W-3:0], 2'b00};
        rem_q[k]  <= take ? dif[REM_W-1:0] : sh[REM_W-1:0];
        root_q[k] <= {root_p[ROOT_W-2:0], take};
        side_q[k] <= side_p;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign side_out  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: tb/circle_contact_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle contact checker
// Watches both channels of the circle contact unit, works out the contact
// result of every accepted query and compares each accepted result with it.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_contact_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] circle_x,
  input  wire logic signed [31:0] circle_y,
  input  wire logic [29:0]        circle_radius,
  input  wire logic signed [31:0] seg_start_x,
  input  wire logic signed [31:0] seg_start_y,
  input  wire logic signed [31:0] seg_end_x,
  input  wire logic signed [31:0] seg_end_y,
  input  wire logic [29:0]        second_radius,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               hit,
  input  wire logic signed [17:0] normal_x,
  input  wire logic signed [17:0] normal_y,
  input  wire logic [30:0]        penetration,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic               degenerate,
  output int                      fail_count,
  output int                      pending
);

  localparam int FB = 16;

  typedef struct packed {
    logic               hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [30:0]        pen;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               degen;
  } contact_t;

  contact_t contacts_due[$];

  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    m = (m + (128'd1 << (FB - 1))) >> FB;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [127:0] sat_word(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic contact_t contact_of(
    input logic [1:0] md, input logic signed [31:0] cx, input logic signed [31:0] cy,
    input logic [29:0] r1, input logic signed [31:0] sx, input logic signed [31:0] sy,
    input logic signed [31:0] ex, input logic signed [31:0] ey, input logic [29:0] r2);
    contact_t c;
    logic signed [127:0] ddx, ddy, wx, wy, dotwd, dotdd, t, clx, cly, dx, dy;
    logic signed [127:0] nxv, nyv, ox, oy, ptx, pty, lim, sq, len;
    c = '0;
    if (md == ccu_pkg::MODE_NONE) return c;
    clx = sx;
    cly = sy;
    if (md != ccu_pkg::MODE_CIRCLE) begin
      ddx = ex - sx;
      ddy = ey - sy;
      wx = cx - sx;
      wy = cy - sy;
      dotwd = wx * ddx + wy * ddy;
      dotdd = ddx * ddx + ddy * ddy;
      if (dotdd == 0 || dotwd <= 0) t = 0;
      else if (dotwd >= dotdd) t = 128'sd1 <<< FB;
      else t = (dotwd <<< FB) / dotdd;
      clx = sx + round_shift(ddx * t);
      cly = sy + round_shift(ddy * t);
    end
    if (md == ccu_pkg::MODE_SEG) begin
      dx = cx - clx;
      dy = cy - cly;
      lim = r1;
    end else begin
      dx = clx - cx;
      dy = cly - cy;
      lim = r1 + r2;
    end
    sq = dx * dx + dy * dy;
    if (sq > lim * lim) return c;
    len = int_sqrt(sq[63:0]);
    c.hit = 1'b1;
    c.pen = 31'(lim - len);
    ptx = cx;
    pty = cy;
    nxv = 0;
    nyv = 0;
    if (sq == 0) begin
      c.degen = 1'b1;
    end else begin
      nxv = (dx <<< FB) / len;
      nyv = (dy <<< FB) / len;
      ox = round_shift(nxv * r1);
      oy = round_shift(nyv * r1);
      if (md == ccu_pkg::MODE_SEG) begin
        ptx = sat_word(cx - ox);
        pty = sat_word(cy - oy);
      end else begin
        ptx = sat_word(cx + ox);
        pty = sat_word(cy + oy);
      end
    end
    c.nx = nxv[17:0];
    c.ny = nyv[17:0];
    c.px = ptx[31:0];
    c.py = pty[31:0];
    return c;
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    contact_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        contacts_due.push_back(contact_of(mode, circle_x, circle_y, circle_radius,
          seg_start_x, seg_start_y, seg_end_x, seg_end_y, second_radius));
      if (out_valid && !out_stall) begin
        if (contacts_due.size() == 0) begin
          $display("%0t: result with no query waiting", $realtime);
          fail_count++;
        end else begin
          want = contacts_due.pop_front();
          compare("hit", want.hit, hit);
          compare("normal_x", 32'(want.nx), 32'(normal_x));
          compare("normal_y", 32'(want.ny), 32'(normal_y));
          compare("penetration", want.pen, penetration);
          compare("point_x", want.px, point_x);
          compare("point_y", want.py, point_y);
          compare("degenerate", want.degen, degenerate);
        end
      end
    end
    pending = contacts_due.size();
  end

endmodule

`default_nettype wire

// File: tb/circle_contact_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle contact unit testbench
// Drives directed and random collision queries in bursts against a stalling
// receiver and takes its verdict from the contact checker.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_contact_unit_test;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic signed [31:0] circle_x, circle_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic [29:0]        circle_radius, second_radius;
  logic               out_valid;
  logic               out_stall;
  logic               hit, degenerate;
  logic signed [17:0] normal_x, normal_y;
  logic [30:0]        penetration;
  logic signed [31:0] point_x, point_y;
  int                 fail_count;
  int                 pending;
  bit                 hold_off;

  circle_contact_unit u_dut (.*);

  circle_contact_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("circle_contact_unit_test: FAIL");
    $finish;
  end

  function automatic logic signed [31:0] rand_coord(input int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      2: return 32'sh7fff_ffff - $urandom_range(0, 32'h0010_0000);
      default: return 32'sh8000_0000 + $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  task automatic send(input logic [1:0] md, input logic signed [31:0] cx,
                      input logic signed [31:0] cy, input logic [29:0] r1,
                      input logic signed [31:0] sx, input logic signed [31:0] sy,
                      input logic signed [31:0] ex, input logic signed [31:0] ey,
                      input logic [29:0] r2);
    in_valid <= 1'b1;
    mode <= md;
    circle_x <= cx;
    circle_y <= cy;
    circle_radius <= r1;
    seg_start_x <= sx;
    seg_start_y <= sy;
    seg_end_x <= ex;
    seg_end_y <= ey;
    second_radius <= r2;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    int kind;
    logic signed [31:0] cx, cy;
    logic [29:0] r1, r2;
    kind = $urandom_range(0, 9);
    cx = rand_coord(kind < 6 ? 1 : $urandom_range(0, 3));
    cy = rand_coord(kind < 6 ? 1 : $urandom_range(0, 3));
    r1 = kind < 7 ? 30'($urandom_range(0, 32'h0020_0000)) : 30'($urandom());
    r2 = kind < 7 ? 30'($urandom_range(0, 32'h0020_0000)) : 30'($urandom());
    if (kind < 6)
      send(2'($urandom_range(0, 2)), cx, cy, r1,
           cx + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
           cy + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
           cx + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
           cy + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000, r2);
    else
      send(2'($urandom_range(0, 3)), cx, cy, r1, rand_coord($urandom_range(0, 3)),
           rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
           rand_coord($urandom_range(0, 3)), r2);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 7) < 2) && ($realtime > 30us || $realtime < 10us);
  end

  initial begin
    hold_off = 1'b0;
    wait (!rst);
    #3us;
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = ccu_pkg::MODE_SEG;
    {circle_x, circle_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y} = '0;
    circle_radius = '0;
    second_radius = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ccu_pkg::MODE_SEG, 0, 0, 30'h10000, -32'sh20000, 32'sh8000,
         32'sh20000, 32'sh8000, 0);
    send(ccu_pkg::MODE_SEG, 0, 0, 30'h10000, 32'sh8000, 32'sh8000,
         32'sh8000, 32'sh8000, 0);
    send(ccu_pkg::MODE_SEG, 32'sh50000, 0, 30'h10000, 0, 0, 32'sh40000, 0, 0);
    send(ccu_pkg::MODE_SEG, 0, 0, 30'h10000, -32'sh10000, 0, 32'sh10000, 0, 0);
    send(ccu_pkg::MODE_SEG, 0, 0, 30'h10000, 32'sh30000, 0, 32'sh40000, 0, 0);
    send(ccu_pkg::MODE_THICK, 0, 0, 30'h10000, 32'sh18000, 0,
         32'sh18000, 32'sh40000, 30'h10000);
    send(ccu_pkg::MODE_THICK, 0, 0, 30'h3fffffff, 32'sh7fffffff, 32'sh7fffffff,
         -32'sh80000000, -32'sh80000000, 30'h3fffffff);
    send(ccu_pkg::MODE_CIRCLE, 0, 0, 30'h10000, 32'sh10000, 32'sh10000, 0, 0, 30'h10000);
    send(ccu_pkg::MODE_CIRCLE, 32'sh1234, 32'sh5678, 30'h8000, 32'sh1234, 32'sh5678,
         0, 0, 0);
    send(ccu_pkg::MODE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ccu_pkg::MODE_CIRCLE, 32'sh7fffffff, 32'sh7fffffff, 30'h3fffffff,
         -32'sh80000000, -32'sh80000000, 0, 0, 30'h3fffffff);
    send(ccu_pkg::MODE_CIRCLE, 32'sh7fff0000, 0, 30'h3fffffff, 32'sh7ffe0000, 0,
         0, 0, 30'h10);
    send(ccu_pkg::MODE_CIRCLE, -32'sh7fff0000, 0, 30'h3fffffff, -32'sh7ffe0000, 0,
         0, 0, 30'h10);
    send(ccu_pkg::MODE_NONE, -1, -1, 30'h3fffffff, -1, -1, -1, -1, 30'h3fffffff);
    send(ccu_pkg::MODE_SEG, -32'sh80000000, 32'sh7fffffff, 30'h3fffffff,
         32'sh7fffffff, -32'sh80000000, -32'sh80000000, 32'sh7fffffff, 0);

    for (int n = 0; n < 1400; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_random();
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("circle_contact_unit_test: PASS");
    end else begin
      $display("circle_contact_unit_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/ccu_pkg.sv
rtl/ccu_div.sv
rtl/ccu_sqrt.sv
rtl/circle_contact_unit.sv
tb/circle_contact_checker.sv
tb/circle_contact_unit_test.sv
